### rtl/clpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clamped piecewise-linear interpolator - shared definitions
// Field widths, register indexes, region codes, reset values and the
// sequencer state type.
// ----------------------------------------------------------------------------
package clpi_pkg;

   // Field widths
   localparam int COORD_W  = 24;
   localparam int VALUE_W  = 16;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int REGION_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Table depth default
   localparam int MAX_POINTS_DEFAULT = 64;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COORD_OFFSET  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_IN_USE = 2'd1;

   // Register reset values
   localparam logic signed [COORD_W-1:0] COORD_OFFSET_RESET  = 24'sd29000;
   localparam logic [COUNT_W-1:0]        POINTS_IN_USE_RESET = 7'd34;

   // Saturation limits of a coordinate
   localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;

   // Region codes
   localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd0;
   localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
   localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

   // Quotient bits produced by the divider
   localparam int QUO_W  = VALUE_W;
   localparam int PROD_W = COORD_W + 1 + VALUE_W + 1;
   localparam int MAG_W  = COORD_W + QUO_W;

   // Query sequencer
   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_CHK_FIRST = 9'b000000010,
      ST_CHK_LAST  = 9'b000000100,
      ST_SCAN      = 9'b000001000,
      ST_MUL       = 9'b000010000,
      ST_DIV_INIT  = 9'b000100000,
      ST_DIV       = 9'b001000000,
      ST_ADJ       = 9'b010000000,
      ST_FINISH    = 9'b100000000
   } state_type;

endpackage

### rtl/clamped_piecewise_linear_interp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clamped piecewise-linear interpolation unit
// Breakpoint table in on-chip memory, segment search and a radix-2 divider.
// ----------------------------------------------------------------------------
// A load transaction writes one breakpoint (coordinate, value) into the table.
// A query transaction adds the coordinate offset with saturation, checks
// against the first and the last point in use and, when inside, walks the
// segments from the start until one contains the coordinate, then
// interpolates. A hit on a zero-length segment, or a walk that finds no
// segment in an unordered table, ends without using the divider. The walk
// reads one entry per cycle through the single read port of the breakpoint
// memory, and the divider retires one quotient bit per cycle. The next
// transaction is taken as soon as the result is in the output register.
// Configuration writes are always accepted and must only be made while idle.
// ----------------------------------------------------------------------------
module clamped_piecewise_linear_interp_unit #(
   parameter int MAX_POINTS = clpi_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // query / load channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_opcode,
   input  logic [clpi_pkg::INDEX_W-1:0]            req_point_index,
   input  logic signed [clpi_pkg::COORD_W-1:0]     req_point_coord,
   input  logic [clpi_pkg::VALUE_W-1:0]            req_point_value,
   input  logic signed [clpi_pkg::COORD_W-1:0]     req_query_coord,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [clpi_pkg::VALUE_W-1:0]            rsp_interp_value,
   output logic [clpi_pkg::REGION_W-1:0]           rsp_region,
   // register write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [clpi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [clpi_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int CW = clpi_pkg::COORD_W;
   localparam int VW = clpi_pkg::VALUE_W;
   localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int NW_RAW = $clog2(MAX_POINTS + 1);
   localparam int NW = (NW_RAW > clpi_pkg::COUNT_W) ? NW_RAW : clpi_pkg::COUNT_W;
   localparam int IW = (AW > clpi_pkg::INDEX_W) ? AW + 1 : clpi_pkg::INDEX_W + 1;

   // Configuration registers
   logic signed [CW-1:0]             coord_offset_ff;
   logic [clpi_pkg::COUNT_W-1:0]     points_in_use_ff;

   // Breakpoint memories and their read port
   logic signed [CW-1:0] coord_mem_ff [MAX_POINTS];
   logic [VW-1:0]        value_mem_ff [MAX_POINTS];
   logic signed [CW-1:0] rd_coord_ff;
   logic [VW-1:0]        rd_value_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;

   // Sequencer
   clpi_pkg::state_type  state_ff, state_in;
   logic signed [CW-1:0] q_ff, q_in;
   logic [AW-1:0]        last_ff, last_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic signed [CW-1:0] left_coord_ff, left_coord_in;
   logic [VW-1:0]        left_value_ff, left_value_in;
   logic [VW-1:0]        last_value_ff, last_value_in;

   // Arithmetic
   logic [CW-1:0]                           dq_ff, dq_in;
   logic [CW-1:0]                           den_ff, den_in;
   logic signed [VW:0]                      dv_ff, dv_in;
   logic signed [clpi_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic                                    neg_ff, neg_in;
   logic [CW-1:0]                           rem_ff, rem_in;
   logic [clpi_pkg::QUO_W-1:0]              quo_ff, quo_in;
   logic [3:0]                              cnt_ff, cnt_in;

   // Result staging and output register
   logic [VW-1:0]                  res_value_ff, res_value_in;
   logic [clpi_pkg::REGION_W-1:0]  res_region_ff, res_region_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                  rsp_value_ff, rsp_value_in;
   logic [clpi_pkg::REGION_W-1:0]  rsp_region_ff, rsp_region_in;

   // Combinational helpers
   logic signed [CW:0]             q_sum;
   logic signed [CW-1:0]           q_sat;
   logic [NW-1:0]                  pin_ext;
   logic [NW-1:0]                  n_clamped;
   logic [IW-1:0]                  load_idx;
   logic                           seg_hit;
   logic [CW:0]                    den_full;
   logic [clpi_pkg::PROD_W-1:0]    prod_abs;
   logic [CW:0]                    trial;
   logic signed [VW+1:0]           adj_sum;
   logic                           req_fire;
   logic                           out_free;

   assign req_ready = (state_ff == clpi_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_region       = rsp_region_ff;

   // Offset addition with signed saturation
   always_comb begin
      q_sum = {req_query_coord[CW-1], req_query_coord}
            + {coord_offset_ff[CW-1], coord_offset_ff};
      if (q_sum[CW] != q_sum[CW-1]) begin
         q_sat = q_sum[CW] ? clpi_pkg::COORD_MIN : clpi_pkg::COORD_MAX;
      end else begin
         q_sat = q_sum[CW-1:0];
      end
   end

   // Table size clamped to 2..MAX_POINTS
   always_comb begin
      pin_ext = NW'(points_in_use_ff);
      if (pin_ext < NW'(2)) begin
         n_clamped = NW'(2);
      end else if (pin_ext > NW'(MAX_POINTS)) begin
         n_clamped = NW'(MAX_POINTS);
      end else begin
         n_clamped = pin_ext;
      end
   end

   // Load address check
   assign load_idx = IW'(req_point_index);
   assign wr_en    = req_fire && (req_opcode == clpi_pkg::OP_LOAD)
                     && (load_idx < IW'(MAX_POINTS));
   assign wr_addr  = AW'(req_point_index);

   // Segment test against the held left point and the freshly read right one
   assign seg_hit  = (q_ff >= left_coord_ff) && (q_ff <= rd_coord_ff);
   assign den_full = {rd_coord_ff[CW-1], rd_coord_ff}
                   - {left_coord_ff[CW-1], left_coord_ff};

   // Divider helpers
   assign prod_abs = prod_ff[clpi_pkg::PROD_W-1] ? (-prod_ff) : prod_ff;
   assign trial    = {rem_ff, quo_ff[clpi_pkg::QUO_W-1]};
   assign adj_sum  = neg_ff ? ($signed({2'b00, left_value_ff}) - $signed({2'b00, quo_ff}))
                            : ($signed({2'b00, left_value_ff}) + $signed({2'b00, quo_ff}));

   // Sequencer next state and datapath
   always_comb begin
      state_in      = state_ff;
      q_in          = q_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      left_coord_in = left_coord_ff;
      left_value_in = left_value_ff;
      last_value_in = last_value_ff;
      dq_in         = dq_ff;
      den_in        = den_ff;
      dv_in         = dv_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      res_value_in  = res_value_ff;
      res_region_in = res_region_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_region_in = rsp_region_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         clpi_pkg::ST_IDLE: begin
            if (req_fire && (req_opcode == clpi_pkg::OP_QUERY)) begin
               q_in     = q_sat;
               last_in  = AW'(n_clamped - NW'(1));
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = clpi_pkg::ST_CHK_FIRST;
            end
         end
         // First point: clamp below
         clpi_pkg::ST_CHK_FIRST: begin
            left_coord_in = rd_coord_ff;
            left_value_in = rd_value_ff;
            if (q_ff <= rd_coord_ff) begin
               res_value_in  = rd_value_ff;
               res_region_in = clpi_pkg::REGION_BELOW;
               state_in      = clpi_pkg::ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = last_ff;
               state_in = clpi_pkg::ST_CHK_LAST;
            end
         end
         // Last point in use: clamp above
         clpi_pkg::ST_CHK_LAST: begin
            last_value_in = rd_value_ff;
            if (q_ff >= rd_coord_ff) begin
               res_value_in  = rd_value_ff;
               res_region_in = clpi_pkg::REGION_ABOVE;
               state_in      = clpi_pkg::ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(1);
               idx_in   = AW'(1);
               state_in = clpi_pkg::ST_SCAN;
            end
         end
         // Walk segments one entry per cycle
         clpi_pkg::ST_SCAN: begin
            if (seg_hit) begin
               dq_in  = CW'({q_ff[CW-1], q_ff} - {left_coord_ff[CW-1], left_coord_ff});
               den_in = den_full[CW-1:0];
               dv_in  = $signed({1'b0, rd_value_ff}) - $signed({1'b0, left_value_ff});
               if (den_full == '0) begin
                  res_value_in  = left_value_ff;
                  res_region_in = clpi_pkg::REGION_INSIDE;
                  state_in      = clpi_pkg::ST_FINISH;
               end else begin
                  state_in = clpi_pkg::ST_MUL;
               end
            end else if (idx_ff == last_ff) begin
               // no segment matched on a non-ascending table
               res_value_in  = last_value_ff;
               res_region_in = clpi_pkg::REGION_ABOVE;
               state_in      = clpi_pkg::ST_FINISH;
            end else begin
               left_coord_in = rd_coord_ff;
               left_value_in = rd_value_ff;
               idx_in        = idx_ff + AW'(1);
               rd_en         = 1'b1;
               rd_addr       = idx_ff + AW'(1);
            end
         end
         clpi_pkg::ST_MUL: begin
            prod_in  = $signed({1'b0, dq_ff}) * dv_ff;
            state_in = clpi_pkg::ST_DIV_INIT;
         end
         // Magnitude split: high part is already below the divisor
         clpi_pkg::ST_DIV_INIT: begin
            neg_in   = prod_ff[clpi_pkg::PROD_W-1];
            rem_in   = prod_abs[clpi_pkg::MAG_W-1:clpi_pkg::QUO_W];
            quo_in   = prod_abs[clpi_pkg::QUO_W-1:0];
            cnt_in   = '0;
            state_in = clpi_pkg::ST_DIV;
         end
         // Restoring division, one quotient bit per cycle
         clpi_pkg::ST_DIV: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = CW'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[clpi_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CW-1:0];
               quo_in = {quo_ff[clpi_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = clpi_pkg::ST_ADJ;
            end
         end
         // Apply signed quotient to the left value, clamp to the value range
         clpi_pkg::ST_ADJ: begin
            if (adj_sum[VW+1]) begin
               res_value_in = '0;
            end else if (adj_sum[VW]) begin
               res_value_in = '1;
            end else begin
               res_value_in = adj_sum[VW-1:0];
            end
            res_region_in = clpi_pkg::REGION_INSIDE;
            state_in      = clpi_pkg::ST_FINISH;
         end
         clpi_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_region_in = res_region_ff;
               state_in      = clpi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clpi_pkg::ST_IDLE;
         end
      endcase
   end

   // Breakpoint memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coord_mem_ff[wr_addr] <= req_point_coord;
         value_mem_ff[wr_addr] <= req_point_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_coord_ff <= coord_mem_ff[rd_addr];
         rd_value_ff <= value_mem_ff[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= clpi_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         coord_offset_ff  <= clpi_pkg::COORD_OFFSET_RESET;
         points_in_use_ff <= clpi_pkg::POINTS_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               clpi_pkg::CSR_COORD_OFFSET: begin
                  coord_offset_ff <= csr_data[CW-1:0];
               end
               clpi_pkg::CSR_POINTS_IN_USE: begin
                  points_in_use_ff <= csr_data[clpi_pkg::COUNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      left_coord_ff <= left_coord_in;
      left_value_ff <= left_value_in;
      last_value_ff <= last_value_in;
      dq_ff         <= dq_in;
      den_ff        <= den_in;
      dv_ff         <= dv_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      res_value_ff  <= res_value_in;
      res_region_ff <= res_region_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_region_ff <= rsp_region_in;
   end

endmodule
